/* hw/rtl/hll_pkg.sv */
// Shared types, constants and a helper function for the HyperLogLog sketch.
package hll_pkg;

  localparam int PRECISION = 14;
  localparam int REG_COUNT = 1 << PRECISION;
  localparam int IDX_W     = PRECISION;
  localparam int LOW_BITS  = 32 - PRECISION;
  localparam int MAX_RANK  = 33 - PRECISION;
  localparam int RANK_W    = 5;
  localparam int SUM_W     = 35;
  localparam int ZCNT_W    = 15;
  localparam int RAW_W     = 33;
  localparam int CLS_W     = 2;

  // raw = floor(NUM * 2^(33+2P) / (K_MULT * S))
  localparam int NUM_W     = 13;
  localparam logic [NUM_W-1:0] NUM_C = 13'd7213;
  localparam longint K_MULT = 10 * (1000 * longint'(REG_COUNT) + 79);
  localparam int K_W       = $clog2(K_MULT + 1);
  localparam int S_LO_W    = 18;
  localparam int S_HI_W    = SUM_W - S_LO_W;
  localparam int D_W       = K_W + SUM_W;
  localparam int DIV_STEPS = NUM_W + 33 + 2 * PRECISION;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam longint SMALL_LIMIT = (5 * longint'(REG_COUNT)) / 2;
  localparam longint LARGE_LIMIT = 143165576;

  localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_NORMAL = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;

  localparam logic MODE_INSERT = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [31:0] hash;
  } in_t;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_estimate;
    logic [ZCNT_W-1:0] zero_registers;
    logic [CLS_W-1:0]  range_class;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_WALK,
    ST_DRAIN,
    ST_MUL0,
    ST_MUL1,
    ST_ADD,
    ST_DIV,
    ST_CLASS
  } state_t;

  typedef struct packed {
    logic load;
    logic est_init;
    logic clear_wr;
    logic ins_rd;
    logic ins_wr;
    logic walk_rd;
    logic mul0;
    logic mul1;
    logic add;
    logic div;
    logic cls;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic div_last;
  } status_t;

  // Leading-zero count of the low bits plus one; all-zero gives MAX_RANK.
  function automatic logic [RANK_W-1:0] rank_of(input logic [LOW_BITS-1:0] low);
    logic [RANK_W-1:0] rk;
    rk = RANK_W'(MAX_RANK);
    for (int k = 0; k < LOW_BITS; k++) begin
      if (low[k]) begin
        rk = RANK_W'(LOW_BITS - k);
      end
    end
    return rk;
  endfunction

endpackage

/* hw/rtl/hll_ram.sv */
// Generic single-port RAM with registered read.
module hll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic                     re,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/hll_ctrl.sv */
// Sequencer for clear, insert and estimate transactions.
module hll_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             mode,
  input  hll_pkg::status_t status,
  output hll_pkg::cmd_t    cmd,
  output logic             busy
);
  import hll_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (mode == MODE_INSERT) begin
            state_nxt = ST_INS_RD;
          end else begin
            cmd.est_init = 1'b1;
            state_nxt    = ST_WALK;
          end
        end
      end
      ST_INS_RD: begin
        cmd.ins_rd = 1'b1;
        state_nxt  = ST_INS_WR;
      end
      ST_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk_rd = 1'b1;
        if (status.cnt_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_MUL0;
      ST_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.div_last) state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        cmd.cls   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* hw/rtl/hll_dp.sv */
// Datapath: rank store, register walk, divisor build, long division, class.
module hll_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  hll_pkg::in_t     in_data,
  input  hll_pkg::cmd_t    cmd,
  output hll_pkg::status_t status,
  output logic             out_valid,
  output hll_pkg::out_t    out_data
);
  import hll_pkg::*;

  localparam int CW = D_W + 4;

  logic [31:0]               hash_r;
  logic [IDX_W-1:0]          cnt_r;
  logic                      rd_vld_r;
  logic [SUM_W-1:0]          sum_r;
  logic [ZCNT_W-1:0]         zcnt_r;
  logic [K_W+S_LO_W-1:0]     p0_r;
  logic [K_W+S_HI_W-1:0]     p1_r;
  logic [D_W-1:0]            d_r;
  logic [NUM_W-1:0]          num_r;
  logic [D_W-1:0]            rem_r;
  logic [RAW_W-1:0]          q_r;
  logic                      ovf_r;
  logic [STEP_W-1:0]         step_r;
  logic                      out_valid_r;
  out_t                      out_r;

  logic [IDX_W-1:0]  ram_addr;
  logic              ram_we;
  logic              ram_re;
  logic [RANK_W-1:0] ram_wdata;
  logic [RANK_W-1:0] ram_rdata;
  logic [RANK_W-1:0] new_rank;
  logic [RANK_W-1:0] rk_clamp;
  logic [D_W:0]      r_sh;
  logic              q_bit;
  logic [RAW_W-1:0]  q_sat;
  logic [CW-1:0]     rem15;
  logic [CW-1:0]     d8;
  logic [CLS_W-1:0]  cls;

  assign new_rank = rank_of(hash_r[LOW_BITS-1:0]);

  always_comb begin
    ram_addr  = (cmd.ins_rd || cmd.ins_wr) ? hash_r[31 -: IDX_W] : cnt_r;
    ram_re    = cmd.ins_rd || cmd.walk_rd;
    ram_we    = cmd.clear_wr || (cmd.ins_wr && (new_rank > ram_rdata));
    ram_wdata = cmd.clear_wr ? '0 : new_rank;
  end

  hll_ram #(.WIDTH(RANK_W), .DEPTH(REG_COUNT)) u_rank_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .re    (ram_re),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rk_clamp = (ram_rdata > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : ram_rdata;

  // restoring division step
  assign r_sh  = {rem_r, num_r[NUM_W-1]};
  assign q_bit = (r_sh >= {1'b0, d_r});

  // range class
  assign q_sat = ovf_r ? '1 : q_r;
  assign rem15 = (CW'(rem_r) << 4) - CW'(rem_r);
  assign d8    = CW'(d_r) << 3;

  always_comb begin
    if (sum_r == '0) begin
      cls = CLS_LARGE;
    end else if ((q_sat < RAW_W'(SMALL_LIMIT)) ||
                 ((q_sat == RAW_W'(SMALL_LIMIT)) && (rem_r == '0))) begin
      cls = CLS_SMALL;
    end else if (q_sat < RAW_W'(LARGE_LIMIT)) begin
      cls = CLS_NORMAL;
    end else if (q_sat == RAW_W'(LARGE_LIMIT)) begin
      cls = (rem15 <= d8) ? CLS_NORMAL : CLS_LARGE;
    end else begin
      cls = CLS_LARGE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr || cmd.walk_rd) cnt_r <= cnt_r + 1'b1;
      rd_vld_r    <= cmd.walk_rd;
      if (cmd.add) begin
        step_r <= '0;
      end else if (cmd.div) begin
        step_r <= step_r + 1'b1;
      end
      out_valid_r <= cmd.cls;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) hash_r <= in_data.hash;
    if (cmd.est_init) begin
      sum_r  <= '0;
      zcnt_r <= '0;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + (SUM_W'(1) << (RANK_W'(MAX_RANK) - rk_clamp));
      if ((rk_clamp == '0) && (zcnt_r != '1)) zcnt_r <= zcnt_r + 1'b1;
    end
    if (cmd.mul0) p0_r <= K_W'(K_MULT) * sum_r[S_LO_W-1:0];
    if (cmd.mul1) p1_r <= K_W'(K_MULT) * sum_r[SUM_W-1:S_LO_W];
    if (cmd.add) begin
      d_r   <= D_W'(p0_r) + (D_W'(p1_r) << S_LO_W);
      num_r <= NUM_C;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.div) begin
      num_r <= num_r << 1;
      rem_r <= q_bit ? D_W'(r_sh - {1'b0, d_r}) : D_W'(r_sh);
      q_r   <= {q_r[RAW_W-2:0], q_bit};
      ovf_r <= ovf_r | q_r[RAW_W-1];
    end
    if (cmd.cls) begin
      out_r.raw_estimate   <= (sum_r == '0) ? '1 : q_sat;
      out_r.zero_registers <= zcnt_r;
      out_r.range_class    <= cls;
    end
  end

  assign status.cnt_last = (cnt_r == '1);
  assign status.div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cls |-> (rem_r < d_r)) else $error("division remainder not below divisor");
  a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cls |-> (sum_r != '0)) else $error("walk produced an empty sum");
  a_zcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.walk_rd) |-> (zcnt_r <= ZCNT_W'(REG_COUNT))) else $error("zero count overrun");

endmodule

/* hw/rtl/hyperloglog_sketch.sv */
// Top level of the HyperLogLog cardinality sketch.
// Insert transaction: busy after acceptance through a read, then a conditional write.
// Estimate transaction: busy through the rank RAM walk, drain, MUL0, MUL1, add, divide
//   and class steps, paced by the single-port RAM walk and the one-bit-per-cycle long divider.
// The result strobe comes in the first cycle with busy low again; the receiver cannot stall.
// After reset all REG_COUNT rank RAM entries are cleared, one entry a cycle, with busy high.
module hyperloglog_sketch (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hll_pkg::in_t  in_data,
  output logic          out_valid,
  output hll_pkg::out_t out_data
);
  import hll_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: sequences the clear pass, inserts and estimates (walk, multiply, divide, class).
  hll_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .mode   (in_data.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: rank RAM, accumulators, divisor multiply, divider, result register.
  hll_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
